@@ rtl/set_assoc_tag_store_lru_unit_macros.svh @@
// Assertion macros shared by the tag store RTL.
// No dependencies; include with the bare file name inside a module body.
`ifndef SET_ASSOC_TAG_STORE_LRU_UNIT_MACROS_SVH
`define SET_ASSOC_TAG_STORE_LRU_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SATLRU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SATLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/satlru_pkg.sv @@
// Types, constants and address helpers for the set-associative tag store.
// No dependencies.
package satlru_pkg;

    localparam int WAYS        = 16;
    localparam int SETS        = 64;
    localparam int OFFSET_BITS = 6;
    localparam int ADDR_BITS   = 32;

    localparam int IDX_BITS  = $clog2(SETS);
    localparam int WAY_BITS  = $clog2(WAYS);
    localparam int AGE_BITS  = WAY_BITS;
    localparam int TAG_BITS  = ADDR_BITS - OFFSET_BITS - IDX_BITS;
    localparam int WAYS_P2   = 1 << WAY_BITS;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [TAG_BITS-1:0] tag;
        logic [AGE_BITS-1:0] age;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    localparam int ROW_BITS = $bits(t_row);

    // Set index; fold an index field at or above SETS back into range.
    function automatic logic [IDX_BITS-1:0] set_of(input logic [ADDR_BITS-1:0] a);
        logic [IDX_BITS-1:0] raw;
        raw = a[OFFSET_BITS +: IDX_BITS];
        if ({1'b0, raw} >= (IDX_BITS+1)'(SETS)) begin
            raw = raw - IDX_BITS'(SETS);
        end
        return raw;
    endfunction

    function automatic logic [TAG_BITS-1:0] tag_of(input logic [ADDR_BITS-1:0] a);
        return a[ADDR_BITS-1 -: TAG_BITS];
    endfunction

endpackage

@@ rtl/satlru_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module satlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/set_assoc_tag_store_lru_unit.sv @@
// Set-associative tag store with counter LRU: a new word is accepted only while idle.
// The result strobe follows the read, pick and update steps of the accepted word.
// A new word is not accepted until the single read-modify-write of a set row is done.
// A new word may be accepted in the cycle the previous result strobe is shown.
// Reset clears all set rows at once through per-row valid flops; no clearing pass.
// The receiver cannot stall: the strobe is high for exactly one cycle.
module set_assoc_tag_store_lru_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [1:0]                         i_opcode,
    input  logic [satlru_pkg::ADDR_BITS-1:0]   i_address,
    output logic                               o_busy,
    output logic                               o_valid,
    output logic                               o_found,
    output logic [satlru_pkg::WAY_BITS-1:0]    o_way,
    output logic                               o_dirty_out
);
    import satlru_pkg::*;
    `include "set_assoc_tag_store_lru_unit_macros.svh"

    t_state              r_state, n_state;
    t_op                 r_op;
    logic [IDX_BITS-1:0] r_idx;
    logic [TAG_BITS-1:0] r_tag;
    logic                r_row_ok;
    logic [SETS-1:0]     r_row_vld;
    t_row                r_row;
    logic [WAY_BITS-1:0] r_way;
    logic                r_found;
    logic                r_valid;
    logic                r_o_found;
    logic [WAY_BITS-1:0] r_o_way;
    logic                r_o_dirty;

    logic                accept;
    logic [IDX_BITS-1:0] in_idx;
    logic [ROW_BITS-1:0] ram_rdata;
    logic                ram_we;
    t_row                look_row;
    t_row                new_row;
    logic [WAY_BITS-1:0] n_way;
    logic                n_found;
    logic                new_dirty;

    assign accept = i_start && (r_state == ST_IDLE);
    assign in_idx = set_of(i_address);

    satlru_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (new_row),
        .i_re    (accept),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    // State register and control flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row_vld <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_UPDATE);
            if (ram_we) begin
                r_row_vld[r_idx] <= 1'b1;
            end
        end
    end

    // Next state and control
    always_comb begin
        n_state = r_state;
        ram_we  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                ram_we  = r_found;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Lookup stage: tag match, first invalid way, oldest way by a compare tree
    always_comb begin
        logic [WAYS-1:0]     hit_vec;
        logic [WAY_BITS-1:0] hit_way;
        logic [WAY_BITS-1:0] inv_way;
        logic                any_inv;
        logic [AGE_BITS-1:0] node_age [2*WAYS_P2-1];
        logic [WAY_BITS-1:0] node_way [2*WAYS_P2-1];
        logic [WAY_BITS-1:0] victim;

        look_row = r_row_ok ? t_row'(ram_rdata) : t_row'('0);
        hit_way  = '0;
        inv_way  = '0;
        any_inv  = 1'b0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            hit_vec[w] = look_row[w].valid && (look_row[w].tag == r_tag);
            if (hit_vec[w]) begin
                hit_way = WAY_BITS'(w);
            end
            if (!look_row[w].valid) begin
                inv_way = WAY_BITS'(w);
                any_inv = 1'b1;
            end
        end
        for (int i = 0; i < WAYS_P2; i++) begin
            node_way[WAYS_P2-1+i] = WAY_BITS'(i);
            node_age[WAYS_P2-1+i] = (i < WAYS) ? look_row[i].age : '1;
        end
        // Left child holds the lower ways, so it wins ties
        for (int n = WAYS_P2 - 2; n >= 0; n--) begin
            if (node_age[2*n+2] < node_age[2*n+1]) begin
                node_age[n] = node_age[2*n+2];
                node_way[n] = node_way[2*n+2];
            end else begin
                node_age[n] = node_age[2*n+1];
                node_way[n] = node_way[2*n+1];
            end
        end
        victim = any_inv ? inv_way : node_way[0];

        if (r_op == OP_INSERT) begin
            n_way   = victim;
            n_found = 1'b1;
        end else begin
            n_way   = hit_way;
            n_found = |hit_vec;
        end
    end

    // Update stage: fill, promote, mark dirty or drop the entry
    always_comb begin
        logic [AGE_BITS-1:0] ref_age;
        new_row = r_row;
        ref_age = r_row[r_way].age;
        if (r_found) begin
            if (r_op == OP_REMOVE) begin
                new_row[r_way].valid = 1'b0;
                new_row[r_way].age   = '0;
            end else begin
                if (r_op == OP_INSERT) begin
                    new_row[r_way].valid = 1'b1;
                    new_row[r_way].dirty = 1'b0;
                    new_row[r_way].tag   = r_tag;
                end
                for (int w = 0; w < WAYS; w++) begin
                    if (r_row[w].age > ref_age) begin
                        new_row[w].age = r_row[w].age - 1'b1;
                    end
                end
                new_row[r_way].age = AGE_BITS'(WAYS - 1);
                if (r_op == OP_WRITE) begin
                    new_row[r_way].dirty = 1'b1;
                end
            end
        end
        new_dirty = r_found && new_row[r_way].dirty;
    end

    // Payload flops
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= t_op'(i_opcode);
            r_idx    <= in_idx;
            r_tag    <= tag_of(i_address);
            r_row_ok <= r_row_vld[in_idx];
        end
        if (r_state == ST_LOOK) begin
            r_row   <= look_row;
            r_way   <= n_way;
            r_found <= n_found;
        end
        if (r_state == ST_UPDATE) begin
            r_o_found <= r_found;
            r_o_way   <= r_found ? r_way : '0;
            r_o_dirty <= new_dirty;
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_found     = r_o_found;
    assign o_way       = r_o_way;
    assign o_dirty_out = r_o_dirty;

    `SATLRU_ASSERT_NEXT(a_update_strobes, i_clk, i_rst_n, r_state == ST_UPDATE,
        o_valid && r_state == ST_IDLE, "update did not end in a result strobe")
    `SATLRU_ASSERT_NOW(a_we_in_update, i_clk, i_rst_n, ram_we,
        r_state == ST_UPDATE && r_found, "row written outside the update of a found entry")
    `SATLRU_ASSERT_NEXT(a_insert_places, i_clk, i_rst_n, r_state == ST_LOOK && r_op == OP_INSERT,
        r_found, "insert failed to place an entry")
    `SATLRU_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_valid && !o_found,
        o_way == '0 && !o_dirty_out, "miss result carries a way or dirty bit")
    `SATLRU_ASSERT_NEXT(a_accept_look, i_clk, i_rst_n, i_start && !o_busy,
        r_state == ST_LOOK && o_busy, "accepted word did not start a lookup")

endmodule
